@@ rtl/ffa_pkg.sv @@
// shared types and constants of the first-fit heap allocator
package ffa_pkg;

  localparam int LEN_W  = 17;
  localparam int LINK_W = 16;
  localparam int OFF_W  = 16;
  localparam int TOP_W  = 17;

  localparam logic [TOP_W-1:0] HEAP_TOP_RESET = 17'd16;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
    logic              free;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2
  } alloc_status_t;

endpackage

@@ rtl/ffa_ram.sv @@
// generic single-write, single-read ram with registered read data
module ffa_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
// First-fit heap allocator: block headers live in one ram of HEAP_BYTES/8 entries, read one
// header at a time, in a read state and a check state. The time an allocate takes grows with
// the headers it walks, that of a free with the headers it scans from the heap start. The chain
// walk through the header ram sets the rate. Allocates give one result word each, frees none.
// The next request is taken while a result word still waits on the output; an allocate that
// finishes while the previous word is still held waits with it until the receiver takes it.
module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_size[15:0], block_pointer[31:16]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // data_offset[15:0], alloc_status[17:16], zero pad
);
  import ffa_pkg::*;

  localparam int DEPTH  = HEAP_BYTES / 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int SW     = (ADDR_W > 18) ? ADDR_W : 18;
  localparam int CMP_W  = 26;
  localparam logic [CMP_W-1:0] HEAP_LIM = CMP_W'(HEAP_BYTES);
  localparam logic [TOP_W-1:0] HDR_B    = TOP_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] SPLIT_MIN = LEN_W'(HEADER_BYTES + 8);
  localparam logic [CNT_W-1:0] STEP_MAX = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_TOP, S_A_LINK,
    S_F_B, S_F_N, S_S_RD, S_S_CHK, S_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] slot(input logic [17:0] off);
    logic [SW-1:0] q;
    q = SW'(off >> 3);
    if (q >= SW'(DEPTH)) begin
      q = q - SW'(DEPTH);
    end
    return q[ADDR_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  need_r, need_nxt;
  logic [TOP_W-1:0]  cur_r, cur_nxt;
  logic [TOP_W-1:0]  prev_r, prev_nxt;
  hdr_t              prev_hdr_r, prev_hdr_nxt;
  hdr_t              bd_r, bd_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [TOP_W-1:0]  heap_top_r, heap_top_nxt;
  logic [TOP_W-1:0]  off_r, off_nxt;
  logic [17:0]       split_r, split_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  alloc_status_t     res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  hdr_t              mem_wdata, mem_rdata;
  logic [HDR_W-1:0]  rdata_raw;

  logic [15:0]       req;
  logic [15:0]       ptr;
  logic [16:0]       size_rnd;
  hdr_t              hn;
  logic [TOP_W-1:0]  follow;

  ffa_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_raw)
  );
  assign mem_rdata = hdr_t'(rdata_raw);

  assign req        = in_tdata[15:0];
  assign ptr        = in_tdata[31:16];
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    need_nxt      = need_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_hdr_nxt  = prev_hdr_r;
    bd_nxt        = bd_r;
    steps_nxt     = steps_r;
    heap_top_nxt  = heap_top_r;
    off_nxt       = off_r;
    split_nxt     = split_r;
    res_off_nxt   = res_off_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    size_rnd      = ({1'b0, req} + 17'd7) & ~17'd7;
    hn            = mem_rdata;
    follow        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) begin
            if (req == 16'd0) begin
              res_off_nxt = '0;
              res_st_nxt  = ST_ZERO;
              state_nxt   = S_DONE;
            end else begin
              need_nxt  = size_rnd + LEN_W'(HEADER_BYTES);
              cur_nxt   = HDR_B;
              prev_nxt  = '0;
              steps_nxt = '0;
              state_nxt = S_A_RD;
            end
          end else if ({1'b0, ptr} >= HDR_B &&
                       ({1'b0, ptr} - HDR_B) < heap_top_r) begin
            off_nxt   = {1'b0, ptr} - HDR_B;
            mem_raddr = slot(18'({1'b0, ptr} - HDR_B));
            state_nxt = S_F_B;
          end
        end
      end

      S_A_RD: begin
        if (cur_r < heap_top_r && steps_r < STEP_MAX) begin
          mem_raddr = slot(18'(cur_r));
          state_nxt = S_A_CHK;
        end else begin
          state_nxt = S_A_TOP;
        end
      end

      S_A_CHK: begin
        steps_nxt = steps_r + 1'b1;
        if (mem_rdata.free && mem_rdata.len >= need_r) begin
          res_off_nxt = OFF_W'(cur_r + HDR_B);
          res_st_nxt  = ST_OK;
          mem_we      = 1'b1;
          if ((mem_rdata.len - need_r) >= SPLIT_MIN) begin
            split_nxt      = 18'(cur_r) + 18'(need_r);
            mem_waddr      = slot(18'(cur_r) + 18'(need_r));
            mem_wdata.len  = mem_rdata.len - need_r;
            mem_wdata.link = mem_rdata.link;
            mem_wdata.free = 1'b1;
            state_nxt      = S_A_SPLIT;
          end else begin
            mem_waddr      = slot(18'(cur_r));
            mem_wdata      = mem_rdata;
            mem_wdata.free = 1'b0;
            state_nxt      = S_DONE;
          end
        end else begin
          prev_nxt     = cur_r;
          prev_hdr_nxt = mem_rdata;
          cur_nxt      = TOP_W'(mem_rdata.link);
          state_nxt    = (mem_rdata.link == '0) ? S_A_TOP : S_A_RD;
        end
      end

      S_A_SPLIT: begin
        mem_we         = 1'b1;
        mem_waddr      = slot(18'(cur_r));
        mem_wdata.len  = need_r;
        mem_wdata.link = split_r[15:0];
        mem_wdata.free = 1'b0;
        state_nxt      = S_DONE;
      end

      S_A_TOP: begin
        if (CMP_W'(heap_top_r) + CMP_W'(need_r) > HEAP_LIM) begin
          res_off_nxt = '0;
          res_st_nxt  = ST_OOM;
          state_nxt   = S_DONE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = slot(18'(heap_top_r));
          mem_wdata.len  = need_r;
          mem_wdata.link = '0;
          mem_wdata.free = 1'b0;
          cur_nxt        = heap_top_r;
          heap_top_nxt   = heap_top_r + need_r;
          res_off_nxt    = OFF_W'(heap_top_r + HDR_B);
          res_st_nxt     = ST_OK;
          state_nxt      = (prev_r != '0) ? S_A_LINK : S_DONE;
        end
      end

      S_A_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = slot(18'(prev_r));
        mem_wdata      = prev_hdr_r;
        mem_wdata.link = cur_r[15:0];
        state_nxt      = S_DONE;
      end

      S_F_B: begin
        bd_nxt      = mem_rdata;
        bd_nxt.free = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = slot(18'(off_r));
        mem_wdata   = bd_nxt;
        cur_nxt     = TOP_W'(mem_rdata.link);
        steps_nxt   = '0;
        split_nxt   = 18'(HDR_B);
        if (mem_rdata.link != '0 && CMP_W'(mem_rdata.link) < HEAP_LIM) begin
          mem_raddr = slot(18'(mem_rdata.link));
          state_nxt = S_F_N;
        end else begin
          state_nxt = S_S_RD;
        end
      end

      S_F_N: begin
        hn = (slot(18'(cur_r)) == slot(18'(off_r))) ? bd_r : mem_rdata;
        if (hn.free) begin
          bd_nxt.len  = bd_r.len + hn.len;
          bd_nxt.link = hn.link;
          mem_we      = 1'b1;
          mem_waddr   = slot(18'(off_r));
          mem_wdata   = bd_nxt;
        end
        state_nxt = S_S_RD;
      end

      S_S_RD: begin
        if (split_r < 18'(off_r) && steps_r < STEP_MAX) begin
          mem_raddr = slot(split_r);
          state_nxt = S_S_CHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_S_CHK: begin
        steps_nxt = steps_r + 1'b1;
        follow    = (mem_rdata.link != '0) ? TOP_W'(mem_rdata.link) : heap_top_r;
        if (follow == off_r && mem_rdata.free) begin
          mem_we         = 1'b1;
          mem_waddr      = slot(split_r);
          mem_wdata.len  = mem_rdata.len + bd_r.len;
          mem_wdata.link = bd_r.link;
          mem_wdata.free = mem_rdata.free;
          state_nxt      = S_IDLE;
        end else if (mem_rdata.link == '0) begin
          state_nxt = S_IDLE;
        end else begin
          split_nxt = 18'(mem_rdata.link);
          state_nxt = S_S_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_st_r, res_off_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heap_top_r  <= HEAP_TOP_RESET;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      heap_top_r  <= heap_top_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
    end
    need_r     <= need_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    prev_hdr_r <= prev_hdr_nxt;
    bd_r       <= bd_nxt;
    off_r      <= off_nxt;
    split_r    <= split_nxt;
    res_off_r  <= res_off_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/ffa_chk.sv @@
// port-level assertions of the first-fit heap allocator, bound to the top level
module ffa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:16] != 2'd3 && out_tdata[23:18] == 6'd0)
    else $error("bad status code or padding");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] != 2'd0 |-> out_tdata[15:0] == 16'd0)
    else $error("failed allocate with nonzero offset");

endmodule

bind first_fit_heap_allocator_top ffa_chk u_ffa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/first_fit_heap_allocator_top_tb.sv @@
// self-checking testbench of the first-fit heap allocator: directed table, then random traffic
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_tb;
  import ffa_pkg::*;

  localparam int HEAP      = 65536;
  localparam int HDR       = 16;
  localparam int DEPTH     = HEAP / 8;
  localparam int N_RANDOM  = 1620;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_CYC = 2000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct {
    logic          mode;
    int unsigned   size;
    int unsigned   ptr;
    bit            typed;
    int unsigned   off;
    alloc_status_t st;
  } req_row_t;

  typedef struct {
    int unsigned   off;
    alloc_status_t st;
  } alloc_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // request_size[15:0], block_pointer[31:16]
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // data_offset[15:0], alloc_status[17:16], zero pad

  first_fit_heap_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic [LEN_W-1:0]  hp_len [DEPTH];
  logic [LINK_W-1:0] hp_link[DEPTH];
  bit                hp_free[DEPTH];
  int unsigned       hp_top;

  alloc_word_t alloc_q[$];
  int unsigned live_ptrs[$];
  int unsigned dead_ptrs[$];

  int  errors;
  int  n_alloc, n_free, n_oom, n_zero, n_words;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_trigger;
  bit  stim_done;

  function automatic int unsigned slot_of(int unsigned o);
    return (o / 8) % DEPTH;
  endfunction

  function automatic void put_hdr(int unsigned o, int unsigned len, int unsigned lnk, bit fr);
    int unsigned s;
    s = slot_of(o);
    hp_len[s]  = len[LEN_W-1:0];
    hp_link[s] = lnk[LINK_W-1:0];
    hp_free[s] = fr;
  endfunction

  function automatic alloc_word_t predict_alloc(int unsigned req);
    alloc_word_t w;
    int unsigned sz, need, cur, prev, steps, s, rest, at;
    prev = 0;
    steps = 0;
    if (req == 0) begin
      w.off = 0;
      w.st = ST_ZERO;
      return w;
    end
    sz = (req + 7) & ~32'd7;
    need = sz + HDR;
    cur = HDR;
    while (cur < hp_top && steps < DEPTH) begin
      s = slot_of(cur);
      steps++;
      if (hp_free[s] && hp_len[s] >= need) begin
        rest = hp_len[s] - need;
        if (rest >= HDR + 8) begin
          at = cur + need;
          put_hdr(at, rest, hp_link[s], 1'b1);
          hp_len[s]  = need[LEN_W-1:0];
          hp_link[s] = at[LINK_W-1:0];
        end
        hp_free[s] = 1'b0;
        w.off = (cur + HDR) & 32'hFFFF;
        w.st = ST_OK;
        return w;
      end
      prev = cur;
      cur = hp_link[s];
      if (cur == 0) break;
    end
    if (hp_top + need > HEAP) begin
      w.off = 0;
      w.st = ST_OOM;
      return w;
    end
    cur = hp_top;
    put_hdr(cur, need, 0, 1'b0);
    if (prev > 0) hp_link[slot_of(prev)] = cur[LINK_W-1:0];
    hp_top = (cur + need) & 32'h1FFFF;
    w.off = (cur + HDR) & 32'hFFFF;
    w.st = ST_OK;
    return w;
  endfunction

  function automatic void apply_free(int unsigned ptr);
    int unsigned o, b, nx, n, scan, c, follow, steps;
    steps = 0;
    if (ptr < HDR) return;
    o = ptr - HDR;
    if (o >= hp_top) return;
    b = slot_of(o);
    hp_free[b] = 1'b1;
    nx = hp_link[b];
    if (nx > 0 && nx < HEAP) begin
      n = slot_of(nx);
      if (hp_free[n]) begin
        hp_len[b]  = hp_len[b] + hp_len[n];
        hp_link[b] = hp_link[n];
      end
    end
    scan = HDR;
    while (scan < o && steps < DEPTH) begin
      c = slot_of(scan);
      follow = (hp_link[c] != 0) ? hp_link[c] : hp_top;
      steps++;
      if (follow == o && hp_free[c]) begin
        hp_len[c]  = hp_len[c] + hp_len[b];
        hp_link[c] = hp_link[b];
        break;
      end
      if (hp_link[c] == 0) break;
      scan = hp_link[c];
    end
  endfunction

  // free pointer that never touches an unwritten header
  function automatic int unsigned pick_free_ptr();
    int unsigned r, k, p;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, HDR - 1);
    if (r < 16 && hp_top + HDR <= 32'hFFFF) return $urandom_range(hp_top + HDR, 32'hFFFF);
    if (r < 26 && dead_ptrs.size() > 0) return dead_ptrs[$urandom_range(0, dead_ptrs.size()-1)];
    if (live_ptrs.size() > 0) begin
      k = $urandom_range(0, live_ptrs.size() - 1);
      p = live_ptrs[k];
      live_ptrs.delete(k);
      dead_ptrs.push_back(p);
      if (dead_ptrs.size() > 64) void'(dead_ptrs.pop_front());
      return p;
    end
    return $urandom_range(0, HDR - 1);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 70) return $urandom_range(1, 64);
    if (r < 93) return $urandom_range(65, 1024);
    if (r < 97) return $urandom_range(1025, 8192);
    return $urandom_range(0, 65535);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000ms;
    $display("first_fit_heap_allocator_top_tb: FAIL");
    $finish;
  end

  // result side: check accepted words, drive ready
  initial begin
    int hold_left;
    alloc_word_t exp_w;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        n_words++;
        if (alloc_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, actual off=%0d st=%0d", $realtime,
                   out_tdata[15:0], out_tdata[17:16]);
        end else begin
          exp_w = alloc_q.pop_front();
          if (out_tdata[15:0] != exp_w.off[15:0]) begin
            errors++;
            $display("%0t: data_offset expected %0d actual %0d", $realtime,
                     exp_w.off, out_tdata[15:0]);
          end
          if (out_tdata[17:16] != exp_w.st) begin
            errors++;
            $display("%0t: alloc_status expected %0d actual %0d", $realtime,
                     exp_w.st, out_tdata[17:16]);
          end
        end
      end
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_req(logic mode, int unsigned size, int unsigned ptr,
                          bit typed, int unsigned t_off, alloc_status_t t_st);
    alloc_word_t w;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {ptr[15:0], size[15:0]};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_ALLOC) begin
      n_alloc++;
      w = predict_alloc(size);
      if (typed && (w.off != t_off || w.st != t_st))
        $display("%0t: table row disagrees with predictor off=%0d st=%0d", $realtime,
                 t_off, t_st);
      if (typed) begin
        w.off = t_off;
        w.st = t_st;
      end
      if (w.st == ST_OK) live_ptrs.push_back(w.off);
      if (w.st == ST_OOM) n_oom++;
      if (w.st == ST_ZERO) n_zero++;
      alloc_q.push_back(w);
    end else begin
      n_free++;
      apply_free(ptr);
    end
  endtask

  req_row_t dir_tab[] = '{
    '{MODE_ALLOC, 0,     16'hFFFF, 1, 0,  ST_ZERO},
    '{MODE_ALLOC, 1,     0,        1, 32, ST_OK},
    '{MODE_ALLOC, 65535, 16'hAAAA, 1, 0,  ST_OOM},
    '{MODE_ALLOC, 16,    16'h5555, 1, 56, ST_OK},
    '{MODE_ALLOC, 100,   0,        0, 0,  ST_OK},
    '{MODE_ALLOC, 7,     0,        0, 0,  ST_OK},
    '{MODE_FREE,  0,     0,        0, 0,  ST_OK},
    '{MODE_FREE,  16'hFFFF, 16'hFFFF, 0, 0, ST_OK},
    '{MODE_FREE,  0,     15,       0, 0,  ST_OK},
    '{MODE_FREE,  0,     56,       0, 0,  ST_OK},
    '{MODE_FREE,  0,     32,       0, 0,  ST_OK},
    '{MODE_ALLOC, 8,     0,        0, 0,  ST_OK},
    '{MODE_ALLOC, 24,    0,        0, 0,  ST_OK},
    '{MODE_ALLOC, 65520, 0,        1, 0,  ST_OOM},
    '{MODE_ALLOC, 65529, 0,        1, 0,  ST_OOM},
    '{MODE_FREE,  0,     32,       0, 0,  ST_OK},
    '{MODE_ALLOC, 1,     0,        0, 0,  ST_OK},
    '{MODE_ALLOC, 32768, 0,        0, 0,  ST_OK},
    '{MODE_ALLOC, 40000, 0,        1, 0,  ST_OOM},
    '{MODE_FREE,  0,     0,        0, 0,  ST_OK}
  };

  initial begin
    int unsigned p, sz;
    errors = 0; n_alloc = 0; n_free = 0; n_oom = 0; n_zero = 0; n_words = 0;
    hold_trigger = 1'b0;
    stim_done = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 64;
    hp_top = HEAP_TOP_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      hp_len[i] = '0; hp_link[i] = '0; hp_free[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      p = dir_tab[i].ptr;
      // the big block from the table is the one handed back last
      if (i == $size(dir_tab) - 1 && live_ptrs.size() > 0) p = live_ptrs.pop_back();
      send_req(dir_tab[i].mode, dir_tab[i].size, p, dir_tab[i].typed,
               dir_tab[i].off, dir_tab[i].st);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 550) begin
        send_idle_pct = 64;
        recv_idle_pct = 29;
      end
      if (n == 1100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 300) hold_trigger = 1'b1;
      if (n == 800) begin
        in_tvalid <= 1'b0;
        while (alloc_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 52) begin
        sz = pick_size();
        send_req(MODE_ALLOC, sz, $urandom_range(0, 65535), 0, 0, ST_OK);
      end else begin
        sz = $urandom_range(0, 65535);
        send_req(MODE_FREE, sz, pick_free_ptr(), 0, 0, ST_OK);
      end
    end
    in_tvalid <= 1'b0;

    while (alloc_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d allocates (%0d zero size, %0d out of memory), %0d frees",
             n_alloc, n_zero, n_oom, n_free);
    $display("checked %0d result words, heap top ended at %0d", n_words, hp_top);
    if (errors == 0 && alloc_q.size() == 0) begin
      $display("first_fit_heap_allocator_top_tb: PASS");
    end else begin
      $display("first_fit_heap_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_heap_allocator_top.sv
rtl/ffa_chk.sv
tb/first_fit_heap_allocator_top_tb.sv
